@@ rtl/ethernet_mac_register_block_core_defines.svh @@
// Assertion helpers for the MAC register block.
// EMRB_ASSERT_IMP checks the consequence in the same cycle, EMRB_ASSERT_NXT in the next cycle.
`ifndef ETHERNET_MAC_REGISTER_BLOCK_CORE_DEFINES_SVH
`define ETHERNET_MAC_REGISTER_BLOCK_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define EMRB_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("register block assertion failed");
`define EMRB_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("register block assertion failed");
`else
`define EMRB_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define EMRB_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/emrb_pkg.sv @@
package emrb_pkg;

	localparam int unsigned WORD_W        = 16;
	localparam int unsigned LANE_W        = 8;
	localparam int unsigned WADDR_W       = 7;
	localparam int unsigned REG_WORDS_DEF = 128;
	localparam int unsigned PHY_REG_COUNT = 32;
	localparam int unsigned PHY_IDX_W     = $clog2(PHY_REG_COUNT);
	localparam int unsigned RXLEN_W       = 11;

	localparam logic [4:0] PHY_ADDR = 5'd1;

	typedef enum logic [2:0] {
		ACT_READ  = 3'd0,
		ACT_WRITE = 3'd1,
		ACT_RX    = 3'd2,
		ACT_TX    = 3'd3,
		ACT_LINK  = 3'd4
	} action_t;

	// word indexes
	localparam logic [WADDR_W-1:0] W_CTRL0    = 7'h00;
	localparam logic [WADDR_W-1:0] W_CTRL1    = 7'h02;
	localparam logic [WADDR_W-1:0] W_TXPOLL   = 7'h0a;
	localparam logic [WADDR_W-1:0] W_RXBUFSZ  = 7'h0c;
	localparam logic [WADDR_W-1:0] W_MDIO_CTL = 7'h10;
	localparam logic [WADDR_W-1:0] W_MDIO_RD  = 7'h12;
	localparam logic [WADDR_W-1:0] W_MDIO_WR  = 7'h14;
	localparam logic [WADDR_W-1:0] W_STATUS   = 7'h1e;
	localparam logic [WADDR_W-1:0] W_ENABLE   = 7'h20;
	localparam logic [WADDR_W-1:0] W_RXCNT    = 7'h28;
	localparam logic [WADDR_W-1:0] W_TXINC    = 7'h2d;
	localparam logic [WADDR_W-1:0] W_TXCNT    = 7'h2e;
	localparam logic [WADDR_W-1:0] W_MACA     = 7'h34;
	localparam logic [WADDR_W-1:0] W_MACB     = 7'h35;
	localparam logic [WADDR_W-1:0] W_MACC     = 7'h36;
	localparam logic [WADDR_W-1:0] W_PHYSTAT  = 7'h44;

	localparam logic [WORD_W-1:0] RXBUFSZ_RST   = 16'h0600;
	localparam logic [WORD_W-1:0] RXBUF_MASK    = 16'h07fc;
	localparam logic [WORD_W-1:0] MDIO_BUSY     = 16'h6000;
	localparam logic [WORD_W-1:0] CTRL1_DONE    = 16'h0010;
	localparam logic [WORD_W-1:0] MDIO_NO_PHY   = 16'hffff;
	localparam logic [WORD_W-1:0] ST_RX         = 16'h0001;
	localparam logic [WORD_W-1:0] ST_TX         = 16'h0010;
	localparam int unsigned       CTRL0_TX_BIT  = 12;
	localparam int unsigned       CTRL0_RXE_BIT = 1;
	localparam int unsigned       MDIO_RD_BIT   = 13;
	localparam int unsigned       MDIO_WR_BIT   = 14;
	localparam int unsigned       PHY_LINK_REG  = 1;
	localparam int unsigned       PHY_LINK_BIT  = 2;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  byte_address;
		logic        byte_access;
		logic [15:0] write_data;
		logic [15:0] packet_length;
	} cmd_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        irq;
		logic        transmit_request;
		logic [10:0] rx_stored_length;
		logic        receive_enabled;
	} res_t;

	typedef struct packed {
		logic               en;
		logic               wr_lo;
		logic               wr_hi;
		logic [WADDR_W-1:0] addr;
		logic [WORD_W-1:0]  wdata;
	} store_req_t;

	typedef struct packed {
		logic                 mdio_wr;
		logic                 link_up;
		logic [PHY_IDX_W-1:0] idx;
		logic [WORD_W-1:0]    wdata;
	} phy_cmd_t;

	// words with side effects live in flops, never in the word store
	function automatic logic is_special(logic [WADDR_W-1:0] w);
		return w inside {W_CTRL0, W_CTRL1, W_TXPOLL, W_RXBUFSZ, W_MDIO_CTL, W_MDIO_RD,
			W_MDIO_WR, W_STATUS, W_ENABLE, W_RXCNT, W_TXINC, W_TXCNT};
	endfunction

	function automatic logic [WORD_W-1:0] reset_word(logic [WADDR_W-1:0] w);
		logic [WORD_W-1:0] v;
		case (w)
			W_MACA:    v = 16'h5452;
			W_MACB:    v = 16'h1200;
			W_MACC:    v = 16'h5734;
			W_PHYSTAT: v = 16'h9f07;
			default:   v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [WORD_W-1:0] phy_reset(logic [PHY_IDX_W-1:0] i);
		logic [WORD_W-1:0] v;
		case (i)
			PHY_IDX_W'(1): v = 16'h7869;
			PHY_IDX_W'(2): v = 16'h0243;
			PHY_IDX_W'(3): v = 16'h0c54;
			default:       v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/emrb_if.sv @@
interface emrb_cmd_if import emrb_pkg::*;;
	logic valid;
	logic ready;
	cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface emrb_res_if import emrb_pkg::*;;
	logic valid;
	logic ready;
	res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/emrb_ram.sv @@
module emrb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/emrb_word_store.sv @@
module emrb_word_store import emrb_pkg::*; #(
	parameter int unsigned WORDS = REG_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  store_req_t        req,
	output logic [WORD_W-1:0] rdata
);

	localparam int unsigned AW = $clog2(WORDS);

	logic [WADDR_W-1:0] addr_q;
	logic               hit_q;
	logic [WORDS-1:0]   vld_lo_q;
	logic [WORDS-1:0]   vld_hi_q;
	logic [LANE_W-1:0]  lo_rd;
	logic [LANE_W-1:0]  hi_rd;
	logic               in_range;
	logic               we_lo;
	logic               we_hi;
	logic [WORD_W-1:0]  rst_val;

	assign in_range = {1'b0, req.addr} < (WADDR_W+1)'(WORDS);
	assign we_lo    = req.en && req.wr_lo && in_range;
	assign we_hi    = req.en && req.wr_hi && in_range;

	// one RAM per byte lane so byte writes need no read-modify-write
	emrb_ram #(.WIDTH(LANE_W), .DEPTH(WORDS)) u_lo (
		.clk   (clk),
		.we    (we_lo),
		.waddr (req.addr[AW-1:0]),
		.wdata (req.wdata[LANE_W-1:0]),
		.re    (req.en),
		.raddr (req.addr[AW-1:0]),
		.rdata (lo_rd)
	);

	emrb_ram #(.WIDTH(LANE_W), .DEPTH(WORDS)) u_hi (
		.clk   (clk),
		.we    (we_hi),
		.waddr (req.addr[AW-1:0]),
		.wdata (req.wdata[WORD_W-1:LANE_W]),
		.re    (req.en),
		.raddr (req.addr[AW-1:0]),
		.rdata (hi_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			hit_q    <= 1'b0;
			vld_lo_q <= '0;
			vld_hi_q <= '0;
		end else begin
			if (req.en) begin
				addr_q <= req.addr;
				hit_q  <= in_range;
			end
			if (we_lo) begin
				vld_lo_q[req.addr[AW-1:0]] <= 1'b1;
			end
			if (we_hi) begin
				vld_hi_q[req.addr[AW-1:0]] <= 1'b1;
			end
		end
	end

	// a lane never written reads as its reset value
	always_comb begin
		rst_val = reset_word(addr_q);
		rdata   = '0;
		if (hit_q) begin
			rdata[LANE_W-1:0]      = vld_lo_q[addr_q[AW-1:0]] ? lo_rd : rst_val[LANE_W-1:0];
			rdata[WORD_W-1:LANE_W] = vld_hi_q[addr_q[AW-1:0]] ? hi_rd : rst_val[WORD_W-1:LANE_W];
		end
	end

endmodule

@@ rtl/emrb_phy.sv @@
module emrb_phy import emrb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  phy_cmd_t          cmd,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] phy_q [PHY_REG_COUNT];

	assign rdata = phy_q[cmd.idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PHY_REG_COUNT; i++) begin
				phy_q[i] <= phy_reset(PHY_IDX_W'(i));
			end
		end else begin
			if (cmd.mdio_wr) begin
				phy_q[cmd.idx] <= cmd.wdata;
			end
			if (cmd.link_up) begin
				phy_q[PHY_LINK_REG][PHY_LINK_BIT] <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/ethernet_mac_register_block_core.sv @@
// Register block of a small Ethernet MAC with an indirect PHY register port.
// cmd carries one transaction per item: a bus read or write (word or byte)
// or an event (frame received, frame sent, link up). res returns exactly one
// result per command: read data, irq level, transmit pulse, stored receive
// length and the receive enable bit.
// A taken command moves into the command stage, then into the result register that drives res.
// Throughput: one command per cycle while res is not held off; the single stage between the command
// register and the result register holds all the update logic, and the
// plain register words sit in two byte-lane RAMs read at acceptance.
// Reset: the special words and valid flags return to their defaults at once;
// the RAM lanes are marked unwritten by valid flops and read as defaults, so no
// clearing pass runs and cmd.ready is high right after reset.
// Stall: when res is held off the result register keeps its transaction,
// the command stage fills, and cmd.ready drops until res is taken.
`include "ethernet_mac_register_block_core_defines.svh"

module ethernet_mac_register_block_core import emrb_pkg::*; #(
	parameter int unsigned REGISTER_WORDS = REG_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	emrb_cmd_if.sink          cmd,
	emrb_res_if.source        res
);

	// handshake
	logic accept;
	logic out_free;
	logic s1_adv;

	// command stage
	logic               valid_s1;
	logic [2:0]         act_s1;
	logic [7:0]         addr_s1;
	logic               byte_s1;
	logic [WORD_W-1:0]  wdata_s1;
	logic [WORD_W-1:0]  plen_s1;
	logic [WADDR_W-1:0] word_s1;

	// result register
	logic res_valid_q;
	res_t res_q;
	res_t res_d;

	// words with side effects
	logic [WORD_W-1:0] ctrl0_q, ctrl1_q, txpoll_q, rxbufsz_q;
	logic [WORD_W-1:0] mdio_ctl_q, mdio_rd_q, mdio_wr_q, status_q;
	logic [WORD_W-1:0] enable_q, rxcnt_q, txinc_q, txcnt_q;
	logic              mdio_busy_q;

	logic [WORD_W-1:0] ctrl0_d, ctrl1_d, txpoll_d, rxbufsz_d;
	logic [WORD_W-1:0] mdio_ctl_d, mdio_rd_d, mdio_wr_d, status_d;
	logic [WORD_W-1:0] enable_d, rxcnt_d, txinc_d, txcnt_d;
	logic              busy_d;

	store_req_t        store_req;
	logic [WORD_W-1:0] store_rdata;
	phy_cmd_t          phy_cmd;
	logic [WORD_W-1:0] phy_rdata;

	logic [WORD_W-1:0]  cur;
	logic [WORD_W-1:0]  wv;
	logic               gen_wr;
	logic               tx_req;
	logic [RXLEN_W-1:0] rx_len;
	logic [RXLEN_W-1:0] rx_lim;
	logic [WORD_W:0]    rx_sum;
	logic               phy_wr_req;
	logic               link_req;
	logic               mdio_start;

	assign out_free  = !res_valid_q || res.ready;
	assign s1_adv    = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;
	assign accept    = cmd.valid && cmd.ready;

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	assign word_s1 = addr_s1[7:1];

	// plain words go to the lane RAMs at acceptance; specials never do
	always_comb begin
		gen_wr          = cmd.data.action == ACT_WRITE && !is_special(cmd.data.byte_address[7:1]);
		store_req.en    = accept;
		store_req.addr  = cmd.data.byte_address[7:1];
		store_req.wr_lo = gen_wr && (!cmd.data.byte_access || !cmd.data.byte_address[0]);
		store_req.wr_hi = gen_wr && (!cmd.data.byte_access || cmd.data.byte_address[0]);
		store_req.wdata = cmd.data.byte_access ?
			{cmd.data.write_data[LANE_W-1:0], cmd.data.write_data[LANE_W-1:0]} :
			cmd.data.write_data;
	end

	emrb_word_store #(.WORDS(REGISTER_WORDS)) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.rdata  (store_rdata)
	);

	emrb_phy u_phy (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (phy_cmd),
		.rdata  (phy_rdata)
	);

	// current value of the addressed word
	always_comb begin
		case (word_s1)
			W_CTRL0:    cur = ctrl0_q;
			W_CTRL1:    cur = ctrl1_q;
			W_TXPOLL:   cur = txpoll_q;
			W_RXBUFSZ:  cur = rxbufsz_q;
			W_MDIO_CTL: cur = mdio_ctl_q;
			W_MDIO_RD:  cur = mdio_rd_q;
			W_MDIO_WR:  cur = mdio_wr_q;
			W_STATUS:   cur = status_q;
			W_ENABLE:   cur = enable_q;
			W_RXCNT:    cur = rxcnt_q;
			W_TXINC:    cur = txinc_q;
			W_TXCNT:    cur = txcnt_q;
			default:    cur = store_rdata;
		endcase
	end

	// merge a byte write into the current word
	always_comb begin
		if (!byte_s1) begin
			wv = wdata_s1;
		end else if (addr_s1[0]) begin
			wv = {wdata_s1[LANE_W-1:0], cur[LANE_W-1:0]};
		end else begin
			wv = {cur[WORD_W-1:LANE_W], wdata_s1[LANE_W-1:0]};
		end
	end

	assign mdio_start = s1_adv && act_s1 == ACT_WRITE && word_s1 == W_MDIO_CTL;

	// next state of the special words and the result
	always_comb begin
		ctrl0_d    = ctrl0_q;
		ctrl1_d    = ctrl1_q;
		txpoll_d   = txpoll_q;
		rxbufsz_d  = rxbufsz_q;
		mdio_ctl_d = mdio_ctl_q;
		mdio_rd_d  = mdio_rd_q;
		mdio_wr_d  = mdio_wr_q;
		status_d   = status_q;
		enable_d   = enable_q;
		rxcnt_d    = rxcnt_q;
		txinc_d    = txinc_q;
		txcnt_d    = txcnt_q;
		busy_d     = mdio_busy_q;
		tx_req     = 1'b0;
		rx_len     = '0;
		phy_wr_req = 1'b0;
		link_req   = 1'b0;
		rx_lim     = rxbufsz_q[RXLEN_W-1:0] & RXBUF_MASK[RXLEN_W-1:0];
		rx_sum     = {1'b0, plen_s1} + (WORD_W+1)'(4);

		case (act_s1)
			ACT_READ: begin
				case (word_s1)
					W_MDIO_CTL: begin
						// first poll after an MDIO operation drops the busy bits
						if (mdio_busy_q) begin
							mdio_ctl_d = mdio_ctl_q & ~MDIO_BUSY;
							busy_d     = 1'b0;
						end
					end
					W_STATUS: status_d = '0;
					W_RXCNT:  rxcnt_d  = '0;
					W_TXCNT:  txcnt_d  = '0;
					default:  ;
				endcase
			end
			ACT_WRITE: begin
				case (word_s1)
					W_CTRL0: begin
						tx_req  = !ctrl0_q[CTRL0_TX_BIT] && wv[CTRL0_TX_BIT];
						ctrl0_d = wv;
					end
					W_CTRL1:   ctrl1_d = wv[0] ? CTRL1_DONE : wv;
					W_TXPOLL: begin
						tx_req   = wv[0];
						txpoll_d = {wv[WORD_W-1:1], 1'b0};
					end
					W_RXBUFSZ: rxbufsz_d = wv;
					W_MDIO_CTL: begin
						if (wv[MDIO_RD_BIT]) begin
							mdio_rd_d = (wv[12:8] == PHY_ADDR) ? phy_rdata : MDIO_NO_PHY;
						end else if (wv[MDIO_WR_BIT] && wv[12:8] == PHY_ADDR) begin
							phy_wr_req = 1'b1;
						end
						busy_d     = 1'b1;
						mdio_ctl_d = wv | MDIO_BUSY;
					end
					W_MDIO_RD: mdio_rd_d = wv;
					W_MDIO_WR: mdio_wr_d = wv;
					W_ENABLE:  enable_d  = wv;
					W_TXINC:   txinc_d   = wv;
					default:   ;
				endcase
			end
			ACT_RX: begin
				// drop the frame while receive is off
				if (ctrl0_q[CTRL0_RXE_BIT]) begin
					rx_len   = (rx_sum > (WORD_W+1)'(rx_lim)) ? rx_lim : rx_sum[RXLEN_W-1:0];
					rxcnt_d  = rxcnt_q + WORD_W'(1);
					status_d = status_q | ST_RX;
				end
			end
			ACT_TX: begin
				txinc_d  = txinc_q + WORD_W'(1);
				status_d = status_q | ST_TX;
			end
			ACT_LINK: link_req = 1'b1;
			default:  ;
		endcase

		phy_cmd.mdio_wr = s1_adv && phy_wr_req;
		phy_cmd.link_up = s1_adv && link_req;
		phy_cmd.idx     = wv[PHY_IDX_W-1:0];
		phy_cmd.wdata   = mdio_wr_q;

		res_d.read_data        = '0;
		if (act_s1 == ACT_READ) begin
			if (!byte_s1) begin
				res_d.read_data = cur;
			end else if (addr_s1[0]) begin
				res_d.read_data = {{LANE_W{1'b0}}, cur[WORD_W-1:LANE_W]};
			end else begin
				res_d.read_data = {{LANE_W{1'b0}}, cur[LANE_W-1:0]};
			end
		end
		res_d.irq              = |(status_d & enable_d);
		res_d.transmit_request = tx_req;
		res_d.rx_stored_length = rx_len;
		res_d.receive_enabled  = ctrl0_d[CTRL0_RXE_BIT];
	end

	// command stage: load when the stage is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1   <= cmd.data.action;
			addr_s1  <= cmd.data.byte_address;
			byte_s1  <= cmd.data.byte_access;
			wdata_s1 <= cmd.data.write_data;
			plen_s1  <= cmd.data.packet_length;
		end
	end

	// result register: hold while res is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res_d;
		end
	end

	// special words advance with the transaction leaving the command stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl0_q     <= '0;
			ctrl1_q     <= '0;
			txpoll_q    <= '0;
			rxbufsz_q   <= RXBUFSZ_RST;
			mdio_ctl_q  <= '0;
			mdio_rd_q   <= '0;
			mdio_wr_q   <= '0;
			status_q    <= '0;
			enable_q    <= '0;
			rxcnt_q     <= '0;
			txinc_q     <= '0;
			txcnt_q     <= '0;
			mdio_busy_q <= 1'b0;
		end else if (s1_adv) begin
			ctrl0_q     <= ctrl0_d;
			ctrl1_q     <= ctrl1_d;
			txpoll_q    <= txpoll_d;
			rxbufsz_q   <= rxbufsz_d;
			mdio_ctl_q  <= mdio_ctl_d;
			mdio_rd_q   <= mdio_rd_d;
			mdio_wr_q   <= mdio_wr_d;
			status_q    <= status_d;
			enable_q    <= enable_d;
			rxcnt_q     <= rxcnt_d;
			txinc_q     <= txinc_d;
			txcnt_q     <= txcnt_d;
			mdio_busy_q <= busy_d;
		end
	end

	// a full pipeline behind a stalled result must refuse new commands
	`EMRB_ASSERT_IMP(a_stall_blocks_cmd, clk, arst_n, valid_s1 && res_valid_q && !res.ready, !cmd.ready)
	// busy only ever comes from an MDIO control write
	`EMRB_ASSERT_IMP(a_busy_from_mdio, clk, arst_n, $rose(mdio_busy_q), $past(mdio_start))
	// a status read leaves status clear
	`EMRB_ASSERT_NXT(a_status_clears, clk, arst_n, s1_adv && act_s1 == ACT_READ && word_s1 == W_STATUS, status_q == '0)

endmodule
